// File: src/mkif_pkg.sv
package mkif_pkg;

    localparam int MIC_BLOCK_MAX_DEF = 256;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOUND_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOT_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_MAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_OTHER = 3'd4;

    localparam logic [15:0] LONG_PRESS_RST = 16'd800;
    localparam logic [15:0] SOUND_THR_RST  = 16'd8000;
    localparam logic [15:0] DOT_MAX_RST    = 16'd250;
    localparam logic [14:0] TILT_MAIN_RST  = 15'd2458;
    localparam logic [14:0] TILT_OTHER_RST = 15'd2048;

    localparam logic FUNC_POLL   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic [6:0] SYM_DOT     = 7'd46;
    localparam logic [6:0] SYM_DASH    = 7'd45;
    localparam logic [6:0] SYM_SPACE   = 7'd32;
    localparam logic [6:0] SYM_NEWLINE = 7'd10;

    // result slots of one poll word, emitted lowest first
    localparam int SLOT_SPACE0  = 0;
    localparam int SLOT_SPACE1  = 1;
    localparam int SLOT_NEWLINE = 2;
    localparam int SLOT_ACTION  = 3;
    localparam int SLOT_TONE    = 4;
    localparam int NUM_SLOTS    = 5;

    typedef struct packed {
        logic        mode_long;
        logic        act_v;
        logic [6:0]  act_sym;
        logic        tone_clear;
        logic        judge;
        logic        sound_mode;
        logic [31:0] now_ms;
        logic [15:0] thr;
        logic [15:0] dot_max;
    } t_cmd;

endpackage

// File: src/mkif_fifo.sv
module mkif_fifo
    import mkif_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_din,
    input  logic         i_pop,
    output logic [W-1:0] o_dout,
    output logic         o_empty,
    output logic         o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_dout  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_din;
        end
    end

endmodule

// File: src/mkif_front.sv
module mkif_front
    import mkif_pkg::*;
#(
    parameter int MIC_BLOCK_MAX = MIC_BLOCK_MAX_DEF,
    parameter int SUM_W         = $clog2(MIC_BLOCK_MAX) + 16,
    parameter int CNT_W         = $clog2(MIC_BLOCK_MAX + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  logic                  i_full,
    input  logic                  i_func,
    input  logic [31:0]           i_now_ms,
    input  logic                  i_mode_button,
    input  logic                  i_action_button,
    input  logic signed [15:0]    i_accel_x,
    input  logic signed [15:0]    i_accel_y,
    input  logic signed [15:0]    i_accel_z,
    input  logic                  i_accel_valid,
    input  logic signed [15:0]    i_mic_sample,
    input  logic                  i_mic_block_end,
    output logic                  o_push,
    output t_cmd                  o_cmd,
    output logic [SUM_W-1:0]      o_sum,
    output logic [CNT_W-1:0]      o_cnt
);

    logic [15:0] r_long, r_thr, r_dot_max;
    logic [14:0] r_tmain, r_tother;

    logic        r_sound, r_mb_prev, r_ab_prev, r_block_ready;
    logic [31:0] r_mode_press, r_act_press;
    logic [SUM_W-1:0] r_run_sum, r_rdy_sum;
    logic [CNT_W-1:0] r_run_cnt, r_rdy_cnt;

    logic        accept, poll, smp;
    logic        mode_fall, mode_long, mode_short, act_fall, act_long, act_short;
    logic [31:0] mode_dur, act_dur;
    logic        n_sound, tone_clear, judge, act_v, flat, side;
    logic [6:0]  act_sym;
    logic signed [16:0] ax, ay, az, abs_x, abs_y, abs_z, lim_m, lim_o;
    logic signed [16:0] mic_ext, mic_abs;
    logic [SUM_W-1:0] sum_inc;
    logic [CNT_W-1:0] cnt_inc;
    logic        blk_end;

    assign accept = i_valid && !i_full;
    assign poll   = accept && (i_func == FUNC_POLL);
    assign smp    = accept && (i_func == FUNC_SAMPLE);

    always_comb begin
        mode_fall  = !i_mode_button && r_mb_prev;
        mode_dur   = i_now_ms - r_mode_press;
        mode_long  = mode_fall && (mode_dur >= {16'd0, r_long});
        mode_short = mode_fall && !mode_long;
        n_sound    = mode_short ? !r_sound : r_sound;
        tone_clear = mode_short && r_sound;

        act_fall  = !i_action_button && r_ab_prev;
        act_dur   = i_now_ms - r_act_press;
        act_long  = act_fall && (act_dur >= {16'd0, r_long});
        act_short = act_fall && !act_long;

        ax    = {i_accel_x[15], i_accel_x};
        ay    = {i_accel_y[15], i_accel_y};
        az    = {i_accel_z[15], i_accel_z};
        abs_x = (ax < 0) ? -ax : ax;
        abs_y = (ay < 0) ? -ay : ay;
        abs_z = (az < 0) ? -az : az;
        lim_m = {2'b00, r_tmain};
        lim_o = {2'b00, r_tother};
        flat  = (az < -lim_m) && (abs_x < lim_o) && (abs_y < lim_o);
        side  = (ax > lim_m) && (abs_y < lim_o) && (abs_z < lim_o);

        act_v   = act_long || (act_short && !n_sound && i_accel_valid && (flat || side));
        act_sym = act_long ? SYM_SPACE : (flat ? SYM_DOT : SYM_DASH);
        judge   = n_sound && r_block_ready;

        mic_ext = {i_mic_sample[15], i_mic_sample};
        mic_abs = (mic_ext < 0) ? -mic_ext : mic_ext;
        sum_inc = r_run_sum + SUM_W'(mic_abs[15:0]);
        cnt_inc = r_run_cnt + CNT_W'(1);
        blk_end = i_mic_block_end || (cnt_inc >= CNT_W'(MIC_BLOCK_MAX));
    end

    assign o_push = poll && (mode_long || act_v || tone_clear || judge);
    assign o_sum  = r_rdy_sum;
    assign o_cnt  = r_rdy_cnt;

    always_comb begin
        o_cmd            = '0;
        o_cmd.mode_long  = mode_long;
        o_cmd.act_v      = act_v;
        o_cmd.act_sym    = act_sym;
        o_cmd.tone_clear = tone_clear;
        o_cmd.judge      = judge;
        o_cmd.sound_mode = n_sound;
        o_cmd.now_ms     = i_now_ms;
        o_cmd.thr        = r_thr;
        o_cmd.dot_max    = r_dot_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long        <= LONG_PRESS_RST;
            r_thr         <= SOUND_THR_RST;
            r_dot_max     <= DOT_MAX_RST;
            r_tmain       <= TILT_MAIN_RST;
            r_tother      <= TILT_OTHER_RST;
            r_sound       <= 1'b0;
            r_mb_prev     <= 1'b0;
            r_ab_prev     <= 1'b0;
            r_block_ready <= 1'b0;
            r_mode_press  <= '0;
            r_act_press   <= '0;
            r_run_sum     <= '0;
            r_run_cnt     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LONG_PRESS: r_long    <= i_cfg_data;
                    CFG_SOUND_THR:  r_thr     <= i_cfg_data;
                    CFG_DOT_MAX:    r_dot_max <= i_cfg_data;
                    CFG_TILT_MAIN:  r_tmain   <= i_cfg_data[14:0];
                    CFG_TILT_OTHER: r_tother  <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (poll) begin
                r_sound   <= n_sound;
                r_mb_prev <= i_mode_button;
                r_ab_prev <= i_action_button;
                if (i_mode_button && !r_mb_prev) begin
                    r_mode_press <= i_now_ms;
                end
                if (i_action_button && !r_ab_prev) begin
                    r_act_press <= i_now_ms;
                end
                if (judge) begin
                    r_block_ready <= 1'b0;
                end
            end
            if (smp) begin
                // close the block: a pending one not yet judged is replaced
                if (blk_end) begin
                    r_run_sum     <= '0;
                    r_run_cnt     <= '0;
                    r_block_ready <= 1'b1;
                end else begin
                    r_run_sum <= sum_inc;
                    r_run_cnt <= cnt_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (smp && blk_end) begin
            r_rdy_sum <= sum_inc;
            r_rdy_cnt <= cnt_inc;
        end
    end

endmodule

// File: src/mkif_back.sv
module mkif_back
    import mkif_pkg::*;
#(
    parameter int SUM_W = 24,
    parameter int CNT_W = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_cmd             i_cmd,
    input  logic [SUM_W-1:0] i_sum,
    input  logic [CNT_W-1:0] i_cnt,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [6:0]       o_symbol,
    output logic             o_message_end,
    output logic             o_sound_mode,
    output logic             o_last
);

    localparam int PROD_W = 17 + CNT_W;

    // stage 1: threshold plus one times block length
    logic              r_s1_v;
    t_cmd              r_s1_cmd;
    logic [SUM_W-1:0]  r_s1_sum;
    logic [PROD_W-1:0] r_s1_prod;

    // stage 2: result slots still to deliver
    logic                 r_s2_v;
    logic [NUM_SLOTS-1:0] r_mask, new_mask;
    logic [6:0]           r_act_sym, r_tone_sym, tone_sym;
    logic                 r_s2_mode;

    logic        r_tone_active, n_tone_active;
    logic [31:0] r_tone_start, tone_dur;

    logic        out_acc, s2_free, s1_adv, s1_load;
    logic        tone, active_pre, tone_emit, tone_begin;
    logic [16:0] thr_p1;
    logic [PROD_W-1:0] prod;

    assign out_acc = r_s2_v && !i_stall;
    assign o_last  = ((r_mask & (r_mask - NUM_SLOTS'(1))) == '0);
    assign s2_free = !r_s2_v || (out_acc && o_last);
    assign s1_adv  = r_s1_v && s2_free;
    assign s1_load = !r_s1_v || s1_adv;
    assign o_pop   = s1_load && i_q_valid;

    assign thr_p1 = {1'b0, i_cmd.thr} + 17'd1;
    assign prod   = PROD_W'(thr_p1) * PROD_W'(i_cnt);

    // floor(sum / count) > thr is the same as sum >= (thr + 1) * count
    always_comb begin
        tone          = (PROD_W'(r_s1_sum) >= r_s1_prod);
        active_pre    = r_s1_cmd.tone_clear ? 1'b0 : r_tone_active;
        tone_emit     = r_s1_cmd.judge && active_pre && !tone;
        tone_begin    = r_s1_cmd.judge && !active_pre && tone;
        n_tone_active = r_s1_cmd.judge ? tone : active_pre;
        tone_dur      = r_s1_cmd.now_ms - r_tone_start;
        tone_sym      = (tone_dur <= {16'd0, r_s1_cmd.dot_max}) ? SYM_DOT : SYM_DASH;
        new_mask                = '0;
        new_mask[SLOT_SPACE0]  = r_s1_cmd.mode_long;
        new_mask[SLOT_SPACE1]  = r_s1_cmd.mode_long;
        new_mask[SLOT_NEWLINE] = r_s1_cmd.mode_long;
        new_mask[SLOT_ACTION]  = r_s1_cmd.act_v;
        new_mask[SLOT_TONE]    = tone_emit;
    end

    always_comb begin
        o_message_end = 1'b0;
        if (r_mask[SLOT_SPACE0] || r_mask[SLOT_SPACE1]) begin
            o_symbol = SYM_SPACE;
        end else if (r_mask[SLOT_NEWLINE]) begin
            o_symbol      = SYM_NEWLINE;
            o_message_end = 1'b1;
        end else if (r_mask[SLOT_ACTION]) begin
            o_symbol = r_act_sym;
        end else begin
            o_symbol = r_tone_sym;
        end
    end

    assign o_valid      = r_s2_v;
    assign o_sound_mode = r_s2_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v        <= 1'b0;
            r_s2_v        <= 1'b0;
            r_mask        <= '0;
            r_tone_active <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_v <= i_q_valid;
            end
            if (s1_adv) begin
                r_tone_active <= n_tone_active;
            end
            if (s2_free) begin
                r_s2_v <= s1_adv && (new_mask != '0);
                r_mask <= s1_adv ? new_mask : '0;
            end else if (out_acc) begin
                // drop the slot just delivered
                r_mask <= r_mask & (r_mask - NUM_SLOTS'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_cmd  <= i_cmd;
            r_s1_sum  <= i_sum;
            r_s1_prod <= prod;
        end
        if (s1_adv && tone_begin) begin
            r_tone_start <= r_s1_cmd.now_ms;
        end
        if (s2_free) begin
            r_act_sym  <= r_s1_cmd.act_sym;
            r_tone_sym <= tone_sym;
            r_s2_mode  <= r_s1_cmd.sound_mode;
        end
    end

endmodule

// File: src/morse_key_input_frontend.sv
// Morse key input front end.
// Input channel (i_valid / o_stall): one word per cycle while o_stall is low,
// either a poll tick (i_func 0: time, button levels, accelerometer) or a
// microphone sample (i_func 1). A word is taken at a clock edge with i_valid
// high and o_stall low. Output channel (o_valid / i_stall): one symbol per
// cycle while i_stall is low, with message_end, the mode after the poll and a
// last flag on the final symbol of that poll. Configuration: i_cfg_we writes
// i_cfg_data to register i_cfg_index at once. A poll passes through the
// queue and then the two output stages before its first symbol appears.
// One word is taken per cycle while o_stall is low; samples never produce
// symbols, but like polls they wait while the queue is full. A poll yields up
// to five symbols, delivered one per cycle by the output stage while i_stall
// is low; the queue (QUEUE_DEPTH words, 4 by default) between the classifier
// and the output stage absorbs this, and o_stall rises only when it is full.
// Reset clears mode, button history, tone tracking, the microphone block and
// all pipeline valids; registers return to their default values.
// While i_stall is high the shown symbol holds and queued polls wait.
module morse_key_input_frontend
    import mkif_pkg::*;
#(
    parameter int MIC_BLOCK_MAX = MIC_BLOCK_MAX_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_func,
    input  logic [31:0]           i_now_ms,
    input  logic                  i_mode_button,
    input  logic                  i_action_button,
    input  logic signed [15:0]    i_accel_x,
    input  logic signed [15:0]    i_accel_y,
    input  logic signed [15:0]    i_accel_z,
    input  logic                  i_accel_valid,
    input  logic signed [15:0]    i_mic_sample,
    input  logic                  i_mic_block_end,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [6:0]            o_symbol,
    output logic                  o_message_end,
    output logic                  o_sound_mode,
    output logic                  o_last
);

    localparam int SUM_W = $clog2(MIC_BLOCK_MAX) + 16;
    localparam int CNT_W = $clog2(MIC_BLOCK_MAX + 1);
    localparam int Q_W   = $bits(t_cmd) + SUM_W + CNT_W;

    logic             w_push, w_pop, w_empty, w_full;
    t_cmd             w_cmd, w_q_cmd;
    logic [SUM_W-1:0] w_sum, w_q_sum;
    logic [CNT_W-1:0] w_cnt, w_q_cnt;
    logic [Q_W-1:0]   w_q_out;

    assign o_stall = w_full;

    mkif_front #(
        .MIC_BLOCK_MAX(MIC_BLOCK_MAX),
        .SUM_W        (SUM_W),
        .CNT_W        (CNT_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .i_full         (w_full),
        .i_func         (i_func),
        .i_now_ms       (i_now_ms),
        .i_mode_button  (i_mode_button),
        .i_action_button(i_action_button),
        .i_accel_x      (i_accel_x),
        .i_accel_y      (i_accel_y),
        .i_accel_z      (i_accel_z),
        .i_accel_valid  (i_accel_valid),
        .i_mic_sample   (i_mic_sample),
        .i_mic_block_end(i_mic_block_end),
        .o_push         (w_push),
        .o_cmd          (w_cmd),
        .o_sum          (w_sum),
        .o_cnt          (w_cnt)
    );

    mkif_fifo #(
        .W    (Q_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_din  ({w_cmd, w_sum, w_cnt}),
        .i_pop  (w_pop),
        .o_dout (w_q_out),
        .o_empty(w_empty),
        .o_full (w_full)
    );

    assign {w_q_cmd, w_q_sum, w_q_cnt} = w_q_out;

    mkif_back #(
        .SUM_W(SUM_W),
        .CNT_W(CNT_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (!w_empty),
        .i_cmd        (w_q_cmd),
        .i_sum        (w_q_sum),
        .i_cnt        (w_q_cnt),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_symbol     (o_symbol),
        .o_message_end(o_message_end),
        .o_sound_mode (o_sound_mode),
        .o_last       (o_last)
    );

endmodule

// File: src/mkif_checker.sv
module mkif_checker
    import mkif_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [6:0] o_symbol,
    input logic       o_message_end,
    input logic       o_last
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_symbol_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_symbol == SYM_DOT || o_symbol == SYM_DASH ||
                     o_symbol == SYM_SPACE || o_symbol == SYM_NEWLINE))
        else $error("illegal symbol");

    a_end_on_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_message_end) |-> (o_symbol == SYM_NEWLINE))
        else $error("message end off a newline");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_symbol) && $stable(o_last)))
        else $error("stalled word changed");

endmodule

bind morse_key_input_frontend mkif_checker u_mkif_checker (.*);
